// ===== design/hal_pkg.sv =====
package hal_pkg;

	localparam int ROLL_W = 17;
	localparam int PITCH_W = 18;
	localparam int OUT_W = 18;
	localparam int IN_TDATA_W = 40;
	localparam int OUT_TDATA_W = 24;

	localparam int TILT_ROWS = 10;
	localparam int TILT_COLS = 17;
	localparam int ROW_W = $clog2(TILT_ROWS);
	localparam int COL_W = $clog2(TILT_COLS);
	localparam int CNT_W = $clog2(TILT_COLS + 1);
	localparam int TILT_W = 7;

	typedef logic [TILT_W-1:0] tilt_t;

	typedef struct packed {
		logic                      flipped;
		logic signed [PITCH_W-1:0] pitch_angle;
		logic signed [ROLL_W-1:0]  roll_angle;
	} in_item_t;

	// Handle tilt in whole degrees, rows in 5 degree steps of roll magnitude,
	// columns in 5 degree steps of folded pitch starting at 5 degrees.
	localparam tilt_t TILT_ROM [TILT_ROWS][TILT_COLS] = '{
		'{7'd5,  7'd10, 7'd15, 7'd20, 7'd25, 7'd30, 7'd35, 7'd40, 7'd45,
		  7'd50, 7'd55, 7'd60, 7'd65, 7'd70, 7'd75, 7'd80, 7'd85},
		'{7'd7,  7'd11, 7'd16, 7'd21, 7'd25, 7'd30, 7'd35, 7'd40, 7'd45,
		  7'd50, 7'd55, 7'd60, 7'd65, 7'd70, 7'd75, 7'd80, 7'd85},
		'{7'd11, 7'd14, 7'd18, 7'd22, 7'd27, 7'd31, 7'd36, 7'd41, 7'd46,
		  7'd51, 7'd56, 7'd61, 7'd65, 7'd70, 7'd75, 7'd80, 7'd85},
		'{7'd16, 7'd18, 7'd21, 7'd25, 7'd29, 7'd33, 7'd38, 7'd42, 7'd47,
		  7'd52, 7'd56, 7'd61, 7'd66, 7'd71, 7'd76, 7'd80, 7'd85},
		'{7'd21, 7'd22, 7'd25, 7'd28, 7'd32, 7'd36, 7'd40, 7'd44, 7'd48,
		  7'd53, 7'd57, 7'd62, 7'd67, 7'd71, 7'd76, 7'd81, 7'd85},
		'{7'd25, 7'd27, 7'd29, 7'd32, 7'd35, 7'd38, 7'd42, 7'd46, 7'd50,
		  7'd54, 7'd59, 7'd63, 7'd67, 7'd72, 7'd76, 7'd81, 7'd85},
		'{7'd30, 7'd31, 7'd33, 7'd36, 7'd38, 7'd41, 7'd45, 7'd48, 7'd52,
		  7'd56, 7'd60, 7'd64, 7'd69, 7'd73, 7'd77, 7'd81, 7'd86},
		'{7'd35, 7'd36, 7'd38, 7'd40, 7'd42, 7'd45, 7'd48, 7'd51, 7'd55,
		  7'd58, 7'd62, 7'd66, 7'd70, 7'd74, 7'd78, 7'd82, 7'd86},
		'{7'd40, 7'd41, 7'd42, 7'd44, 7'd46, 7'd48, 7'd51, 7'd54, 7'd57,
		  7'd61, 7'd64, 7'd67, 7'd71, 7'd75, 7'd79, 7'd82, 7'd86},
		'{7'd45, 7'd46, 7'd47, 7'd48, 7'd50, 7'd52, 7'd55, 7'd57, 7'd60,
		  7'd63, 7'd66, 7'd69, 7'd73, 7'd76, 7'd79, 7'd83, 7'd86}
	};

endpackage

// ===== design/handle_angle_lookup_unit.sv =====
// Handle tilt lookup: every transfer on the slave side carries a roll angle, a pitch
// angle (both in degrees times FRACTION_SCALE) and a flip flag, and yields exactly one
// transfer on the master side with the handle tilt in the same format, wrapped to 18
// bits. The block takes one item per clock cycle while the output is not stalled; an
// item passes through the input register and then the result register. Between
// them sit the 5 degree step compares, the 10 x 17 tilt ROM read and the scaling.
// The ready chain runs combinationally from m_tready back to s_tready, so a stalled
// output holds at most two items inside.
module handle_angle_lookup_unit
	import hal_pkg::*;
#(
	parameter int FRACTION_SCALE = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [16:0] roll_angle, [34:17] pitch_angle, [35] flipped, [39:36] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [17:0] handle tilt, [23:18] zero
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int Step = 5 * FRACTION_SCALE;
	localparam int AW = $clog2(180 * FRACTION_SCALE + 2 ** ROLL_W + 1) + 1;
	localparam logic signed [AW-1:0] Neg80 = AW'(-80 * FRACTION_SCALE);
	localparam logic signed [AW-1:0] Pos90 = AW'(90 * FRACTION_SCALE);
	localparam logic signed [AW-1:0] Pos180 = AW'(180 * FRACTION_SCALE);

	logic                    valid_s1;
	logic                    valid_s2;
	in_item_t                item_s1;
	logic signed [OUT_W-1:0] handle_s2;
	logic                    adv_s2;

	logic signed [AW-1:0] roll_x;
	logic signed [AW-1:0] pitch_x;
	logic signed [AW-1:0] roll_mag;
	logic signed [AW-1:0] pitch_fold;
	logic [ROW_W-1:0]     row_idx;
	logic [CNT_W-1:0]     col_cnt;
	logic [COL_W-1:0]     col_idx;
	tilt_t                tilt_val;
	logic signed [AW-1:0] tilt_fixed;
	logic signed [AW-1:0] result;

	assign adv_s2 = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
		end
		if (adv_s2 && valid_s1) begin
			handle_s2 <= result[OUT_W-1:0];
		end
	end

	assign roll_x = AW'(item_s1.roll_angle);
	assign pitch_x = AW'(item_s1.pitch_angle);
	assign roll_mag = roll_x[AW-1] ? -roll_x : roll_x;

	// Pitch in -90..270 folds into 0..90 degrees; at or below -80 is caught later.
	always_comb begin
		if (pitch_x[AW-1]) begin
			pitch_fold = -pitch_x;
		end else if (pitch_x >= Pos180) begin
			pitch_fold = pitch_x - Pos180;
		end else if (pitch_x >= Pos90) begin
			pitch_fold = Pos180 - pitch_x;
		end else begin
			pitch_fold = pitch_x;
		end
	end

	// Truncating division by 5 degrees on non-negative values is a count of the
	// step thresholds reached; the thresholds are monotone, so the last hit wins.
	always_comb begin
		row_idx = '0;
		for (int k = 1; k < TILT_ROWS; k++) begin
			if (roll_mag >= AW'(k * Step)) begin
				row_idx = ROW_W'(k);
			end
		end
	end

	always_comb begin
		col_cnt = '0;
		for (int k = 1; k <= TILT_COLS; k++) begin
			if (pitch_fold >= AW'(k * Step)) begin
				col_cnt = CNT_W'(k);
			end
		end
	end

	assign col_idx = COL_W'(col_cnt - CNT_W'(1));
	assign tilt_val = TILT_ROM[row_idx][col_idx];
	assign tilt_fixed = AW'(32'(tilt_val) * FRACTION_SCALE);

	always_comb begin
		if (pitch_x <= Neg80) begin
			result = Neg80;
		end else if (col_cnt == '0) begin
			result = item_s1.flipped ? Pos180 + roll_x : roll_x;
		end else if (col_cnt == CNT_W'(TILT_COLS)) begin
			result = Pos90;
		end else if (pitch_x > Pos90) begin
			result = Pos180 - tilt_fixed;
		end else if (pitch_x[AW-1]) begin
			result = -tilt_fixed;
		end else begin
			result = tilt_fixed;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = OUT_TDATA_W'(unsigned'(handle_s2));

`ifndef SYNTHESIS
	// An item held in the input register while the output stalls must not change.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1 && $stable(item_s1))
	else $error("input stage item changed while stalled");

	// A pitch at or below -80 degrees leaves the pipeline as -80 degrees.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 && (pitch_x <= Neg80)
		|=> m_tvalid && (m_tdata[OUT_W-1:0] == Neg80[OUT_W-1:0]))
	else $error("low pitch clamp lost");

	// Every item that leaves the input stage lands in the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> valid_s2)
	else $error("item dropped between stages");

	// A table hit always uses a column inside the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (col_cnt != '0) && (col_cnt != CNT_W'(TILT_COLS))
		|-> (col_cnt < CNT_W'(TILT_COLS)))
	else $error("column index out of range");
`endif

endmodule
